// ===== rtl/core/lsbm_pkg.sv =====
// Package for the load/store byte memory: operation codes and data constants.
package lsbm_pkg;

  // Default memory size in bytes
  localparam int unsigned MemoryBytesDefault = 16384;

  // Bytes per word and byte lanes of the store
  localparam int unsigned NumLanes = 4;

  // Sign fill and byte mask for byte loads
  localparam logic [31:0] SignFill = 32'hFFFFFF00;
  localparam logic [31:0] ByteMask = 32'h000000FF;
  localparam logic [7:0]  ByteAll  = 8'hFF;

  // Request operations
  typedef enum logic [2:0] {
    OP_LB  = 3'd0,
    OP_LBU = 3'd1,
    OP_LW  = 3'd2,
    OP_SB  = 3'd3,
    OP_SW  = 3'd4
  } op_e;

endpackage

// ===== rtl/core/load_store_byte_memory.sv =====
// Top level of the load/store byte memory: address check, byte-lane store and result stage.

// Byte-addressed data memory for load byte (signed/unsigned), load word,
// store byte and store word. The address is base + offset, wrapping at
// 32 bits; words are little-endian. A byte access at or past MEMORY_BYTES,
// or a word access that is not 4-aligned or runs past the end, faults:
// read_data is zero and nothing is written. Unknown operations fault too.
// One item is accepted per cycle while results are taken. The memory read is
// registered when the item is accepted, and the extended result is then
// loaded into the output register once that register is free or is taken.
// The store is four byte lanes of ceil(MEMORY_BYTES/4) rows each. After
// reset a clearing pass zeroes one row per cycle, all ceil(MEMORY_BYTES/4)
// rows (4096 at the default size), and no item is accepted until it is
// done.
module load_store_byte_memory
  import lsbm_pkg::*;
#(
  parameter int unsigned MEMORY_BYTES = MemoryBytesDefault
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic        [2:0]  op_i,
  input  logic        [31:0] base_i,
  input  logic signed [31:0] offset_i,
  input  logic        [31:0] store_data_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic        [31:0] read_data_o,
  output logic               fault_o
);

  localparam int unsigned Rows = (MEMORY_BYTES + NumLanes - 1) / NumLanes;
  localparam int unsigned RowW = (Rows > 1) ? $clog2(Rows) : 1;
  localparam logic [31:0] ByteLimit = 32'(MEMORY_BYTES);
  localparam logic [31:0] WordLimit = 32'(MEMORY_BYTES - 3);
  localparam logic [RowW-1:0] LastRow = RowW'(Rows - 1);

  // Clearing pass after reset
  logic            clr_q, clr_d;
  logic [RowW-1:0] clr_row_q, clr_row_d;

  // Memory stage and output stage registers
  logic       s1_valid_q, s1_valid_d;
  logic [2:0] s1_op_q;
  logic [1:0] s1_lane_q;
  logic       s1_fault_q;
  logic [7:0] rdata_q [NumLanes];

  logic        out_valid_q, out_valid_d;
  logic [31:0] out_data_q, out_data_d;
  logic        out_fault_q, out_fault_d;

  // Handshake
  logic accept, s1_move;
  assign s1_move    = s1_valid_q && (!out_valid_q || out_ready_i);
  assign in_ready_o = !clr_q && (!s1_valid_q || s1_move);
  assign accept     = in_valid_i && in_ready_o;

  // Address and access check
  logic [31:0]     addr;
  logic [RowW-1:0] acc_row;
  logic [1:0]      acc_lane;
  logic            byte_ok, word_ok, acc_fault, is_store;

  assign addr     = base_i + $unsigned(offset_i);
  assign acc_row  = addr[RowW+1:2];
  assign acc_lane = addr[1:0];
  assign byte_ok  = addr < ByteLimit;
  assign word_ok  = (addr[1:0] == 2'b00) && (addr < WordLimit);

  always_comb begin
    acc_fault = 1'b1;
    is_store  = 1'b0;
    case (op_i)
      OP_LB, OP_LBU: acc_fault = !byte_ok;
      OP_LW:         acc_fault = !word_ok;
      OP_SB: begin
        acc_fault = !byte_ok;
        is_store  = 1'b1;
      end
      OP_SW: begin
        acc_fault = !word_ok;
        is_store  = 1'b1;
      end
      default:       acc_fault = 1'b1;
    endcase
  end

  // Lane write enables, write data and row select
  logic [NumLanes-1:0] we;
  logic [7:0]          wdata [NumLanes];
  logic [RowW-1:0]     wr_row;
  logic                rd_en;

  assign wr_row = clr_q ? clr_row_q : acc_row;
  assign rd_en  = accept;

  always_comb begin
    for (int l = 0; l < NumLanes; l++) begin
      if (clr_q) begin
        we[l]    = 1'b1;
        wdata[l] = 8'h00;
      end else if (op_i == OP_SB) begin
        we[l]    = accept && !acc_fault && (acc_lane == 2'(l));
        wdata[l] = store_data_i[7:0] & ByteAll;
      end else begin
        we[l]    = accept && is_store && !acc_fault;
        wdata[l] = store_data_i[8*l +: 8];
      end
    end
  end

  // Byte lanes of the store
  for (genvar l = 0; l < NumLanes; l++) begin : g_lane
    logic [7:0] mem [Rows];
    always_ff @(posedge clk_i) begin
      if (we[l]) begin
        mem[wr_row] <= wdata[l];
      end
      if (rd_en) begin
        rdata_q[l] <= mem[acc_row];
      end
    end
  end

  // Clearing pass control
  always_comb begin
    clr_d     = clr_q;
    clr_row_d = clr_row_q;
    if (clr_q) begin
      if (clr_row_q == LastRow) begin
        clr_d = 1'b0;
      end else begin
        clr_row_d = clr_row_q + 1'b1;
      end
    end
  end

  // Result formatting
  logic [7:0] sel_byte;
  assign sel_byte = rdata_q[s1_lane_q];

  always_comb begin
    out_fault_d = s1_fault_q;
    out_data_d  = '0;
    if (!s1_fault_q) begin
      case (s1_op_q)
        OP_LB:   out_data_d = sel_byte[7] ? (SignFill | {24'h0, sel_byte})
                                          : (ByteMask & {24'h0, sel_byte});
        OP_LBU:  out_data_d = ByteMask & {24'h0, sel_byte};
        OP_LW:   out_data_d = {rdata_q[3], rdata_q[2], rdata_q[1], rdata_q[0]};
        default: out_data_d = '0;
      endcase
    end
  end

  // Stage valid flags
  always_comb begin
    s1_valid_d = s1_valid_q;
    if (accept) begin
      s1_valid_d = 1'b1;
    end else if (s1_move) begin
      s1_valid_d = 1'b0;
    end
    out_valid_d = out_valid_q;
    if (s1_move) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_q       <= 1'b1;
      clr_row_q   <= '0;
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      clr_q       <= clr_d;
      clr_row_q   <= clr_row_d;
      s1_valid_q  <= s1_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    if (accept) begin
      s1_op_q    <= op_i;
      s1_lane_q  <= acc_lane;
      s1_fault_q <= acc_fault;
    end
    if (s1_move) begin
      out_data_q  <= out_data_d;
      out_fault_q <= out_fault_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign read_data_o = out_data_q;
  assign fault_o     = out_fault_q;

endmodule

// ===== dv/lsbm_access_checker.sv =====
// Checker for the load/store byte memory: predicts each access and compares its result.
module lsbm_access_checker
  import lsbm_pkg::*;
#(
  parameter int unsigned MEMORY_BYTES = MemoryBytesDefault
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  input  logic        in_ready_i,
  input  logic [2:0]  op_i,
  input  logic [31:0] base_i,
  input  logic [31:0] offset_i,
  input  logic [31:0] store_data_i,
  input  logic        out_valid_i,
  input  logic        out_ready_i,
  input  logic [31:0] read_data_i,
  input  logic        fault_i,
  output int          fail_count_o,
  output int          pending_o,
  output int          load_count_o,
  output int          store_count_o,
  output int          fault_count_o
);

  typedef struct packed {
    logic [31:0] read_data;
    logic        fault;
  } access_result_t;

  // Shadow copy of the byte store and results still owed by the block
  logic [7:0]     shadow_mem [MEMORY_BYTES];
  access_result_t expected_results [$];

  // Work out one access against the shadow store, updating it on stores
  function automatic access_result_t predict_access(logic [2:0] op, logic [31:0] base,
                                                    logic [31:0] offset, logic [31:0] data);
    logic [31:0]    addr;
    logic           byte_in;
    logic           word_in;
    access_result_t res;
    addr    = base + offset;
    byte_in = {32'd0, addr} < 64'(MEMORY_BYTES);
    // word end is checked without wrap
    word_in = (addr[1:0] == 2'b00) && ({32'd0, addr} + 64'd3 < 64'(MEMORY_BYTES));
    res     = '0;
    case (op)
      OP_LB, OP_LBU: begin
        if (!byte_in) begin
          res.fault = 1'b1;
        end else if (op == OP_LB && shadow_mem[addr][7]) begin
          res.read_data = SignFill | {24'd0, shadow_mem[addr]};
        end else begin
          res.read_data = ByteMask & {24'd0, shadow_mem[addr]};
        end
      end
      OP_LW: begin
        if (word_in) begin
          res.read_data = {shadow_mem[addr + 3], shadow_mem[addr + 2],
                           shadow_mem[addr + 1], shadow_mem[addr]};
        end else begin
          res.fault = 1'b1;
        end
      end
      OP_SB: begin
        if (byte_in) shadow_mem[addr] = data[7:0] & ByteAll;
        else res.fault = 1'b1;
      end
      OP_SW: begin
        if (word_in) begin
          for (int lane = 0; lane < NumLanes; lane++) begin
            shadow_mem[addr + lane] = data[8*lane +: 8];
          end
        end else begin
          res.fault = 1'b1;
        end
      end
      default: res.fault = 1'b1;
    endcase
    return res;
  endfunction

  // Compare accepted results, then predict the newly accepted item
  always @(posedge clk_i or negedge rst_ni) begin : track
    access_result_t want;
    access_result_t pred;
    if (!rst_ni) begin
      for (int i = 0; i < MEMORY_BYTES; i++) shadow_mem[i] = '0;
      expected_results.delete();
      fail_count_o  = 0;
      pending_o     = 0;
      load_count_o  = 0;
      store_count_o = 0;
      fault_count_o = 0;
    end else begin
      if (out_valid_i && out_ready_i) begin
        if (expected_results.size() == 0) begin
          $error("unexpected result: read_data %h fault %b", read_data_i, fault_i);
          fail_count_o++;
        end else begin
          want = expected_results.pop_front();
          if (read_data_i !== want.read_data) begin
            $error("read_data mismatch: expected %h, got %h", want.read_data, read_data_i);
            fail_count_o++;
          end
          if (fault_i !== want.fault) begin
            $error("fault mismatch: expected %b, got %b", want.fault, fault_i);
            fail_count_o++;
          end
        end
      end
      if (in_valid_i && in_ready_i) begin
        pred = predict_access(op_i, base_i, offset_i, store_data_i);
        expected_results.push_back(pred);
        if (pred.fault) fault_count_o++;
        else if (op_i == OP_SB || op_i == OP_SW) store_count_o++;
        else load_count_o++;
      end
      pending_o = expected_results.size();
    end
  end

endmodule

// ===== dv/testbench.sv =====
// Top of the load/store byte memory testbench: clock, reset, stimulus and verdict.
module testbench
  import lsbm_pkg::*;
();

  localparam int unsigned MemBytes    = MemoryBytesDefault;
  localparam int          RandomItems = 1640;
  localparam int          HoldCycles  = 300;

  // Throttle modes of the random part
  typedef enum int {
    PH_FREE,
    PH_SEND_IDLE,
    PH_RECV_STALL,
    PH_BOTH
  } throttle_e;

  logic        clk          = 1'b0;
  logic        rst_n        = 1'b0;
  logic        in_valid     = 1'b0;
  logic        in_ready;
  logic [2:0]  op           = OP_LB;
  logic [31:0] base         = '0;
  logic [31:0] offset       = '0;
  logic [31:0] store_data   = '0;
  logic        out_valid;
  logic        out_ready    = 1'b0;
  logic [31:0] read_data;
  logic        fault;
  throttle_e   phase        = PH_FREE;
  logic        hold_armed   = 1'b0;

  int fail_count;
  int pending;
  int load_count;
  int store_count;
  int fault_count;

  load_store_byte_memory #(.MEMORY_BYTES(MemBytes)) u_top (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .in_valid_i   (in_valid),
    .in_ready_o   (in_ready),
    .op_i         (op),
    .base_i       (base),
    .offset_i     (offset),
    .store_data_i (store_data),
    .out_valid_o  (out_valid),
    .out_ready_i  (out_ready),
    .read_data_o  (read_data),
    .fault_o      (fault)
  );

  lsbm_access_checker #(.MEMORY_BYTES(MemBytes)) u_checker (
    .clk_i         (clk),
    .rst_ni        (rst_n),
    .in_valid_i    (in_valid),
    .in_ready_i    (in_ready),
    .op_i          (op),
    .base_i        (base),
    .offset_i      (offset),
    .store_data_i  (store_data),
    .out_valid_i   (out_valid),
    .out_ready_i   (out_ready),
    .read_data_i   (read_data),
    .fault_i       (fault),
    .fail_count_o  (fail_count),
    .pending_o     (pending),
    .load_count_o  (load_count),
    .store_count_o (store_count),
    .fault_count_o (fault_count)
  );

  // Clock, period 2
  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  function automatic bit draw_idle(int pct);
    return $urandom_range(99, 0) < pct;
  endfunction

  function automatic int send_idle_pct(throttle_e ph);
    return (ph == PH_SEND_IDLE) ? 56 : (ph == PH_BOTH) ? 12 : 0;
  endfunction

  function automatic int recv_stall_pct(throttle_e ph);
    return (ph == PH_RECV_STALL) ? 56 : (ph == PH_BOTH) ? 12 : 0;
  endfunction

  // Offer one item after an optional gap; return once it is accepted
  task automatic send_req(logic [2:0] req_op, logic [31:0] req_base,
                          logic [31:0] req_offset, logic [31:0] req_data);
    while (draw_idle(send_idle_pct(phase))) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid   <= 1'b1;
    op         <= req_op;
    base       <= req_base;
    offset     <= req_offset;
    store_data <= req_data;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  // Reach an address through a random base and the matching offset
  task automatic send_at(logic [2:0] req_op, logic [31:0] addr, logic [31:0] req_data);
    logic [31:0] b;
    b = $urandom;
    send_req(req_op, b, addr - b, req_data);
  endtask

  // Address for a well-formed access, mostly near both ends of memory
  function automatic logic [31:0] pick_addr();
    int sel;
    sel = $urandom_range(99, 0);
    if (sel < 45) return $urandom_range(63, 0);
    if (sel < 80) return $urandom_range(MemBytes - 1, MemBytes - 64);
    return $urandom_range(MemBytes - 1, 0);
  endfunction

  // Receiver: one long hold-off at the start of the random part, then throttled
  initial begin : receiver
    int hold_left;
    bit hold_done;
    hold_left = 0;
    hold_done = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_left > 0) begin
        hold_left--;
        out_ready <= 1'b0;
      end else if (hold_armed && !hold_done) begin
        hold_done = 1'b1;
        hold_left = HoldCycles - 1;
        out_ready <= 1'b0;
      end else begin
        out_ready <= !draw_idle(recv_stall_pct(phase));
      end
    end
  end

  // Stimulus and verdict
  initial begin : stimulus
    logic [31:0] addr;
    logic [2:0]  req_op;
    int          sel;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: lane order and sign extension at the bottom of memory
    send_at(OP_SW, 32'd0, 32'h80FF7F01);
    send_at(OP_LW, 32'd0, $urandom);
    send_at(OP_LB, 32'd2, $urandom);
    send_at(OP_LBU, 32'd2, $urandom);
    send_at(OP_LB, 32'd1, $urandom);
    send_at(OP_LB, 32'd3, $urandom);
    // last byte and last word
    send_at(OP_SB, MemBytes - 1, 32'hFFFFFF80);
    send_at(OP_LB, MemBytes - 1, $urandom);
    send_at(OP_LBU, MemBytes - 1, $urandom);
    send_at(OP_SW, MemBytes - 4, 32'hFFFFFFFF);
    send_at(OP_LW, MemBytes - 4, $urandom);
    // just past the end, and misaligned words
    send_at(OP_LB, MemBytes, $urandom);
    send_at(OP_SB, MemBytes, $urandom);
    send_at(OP_LW, MemBytes - 3, $urandom);
    send_at(OP_LW, MemBytes, $urandom);
    send_at(OP_SW, 32'd2, 32'hDEADBEEF);
    send_at(OP_LW, 32'd2, $urandom);
    // address wrap in both directions
    send_req(OP_LW, 32'hFFFFFFFF, 32'd1, '0);
    send_req(OP_LBU, 32'h00000100, -32'sd256, '0);
    send_req(OP_SW, 32'd0, -32'sd4, 32'h12345678);
    send_req(OP_LW, 32'hFFFFFFFF, 32'h7FFFFFFF, '0);
    // undefined operations
    for (int k = OP_SW + 1; k < 8; k++) send_at(3'(k), 32'd0, $urandom);
    // store byte ignores the upper data bits
    send_at(OP_SB, 32'd0, 32'hFFFFFF00);
    send_at(OP_LW, 32'd0, $urandom);

    // Random part, four throttle modes
    hold_armed <= 1'b1;
    for (int n = 0; n < RandomItems; n++) begin
      if (n % (RandomItems / 4) == 0) phase <= throttle_e'(n / (RandomItems / 4));
      sel = $urandom_range(99, 0);
      if (sel < 90) begin
        req_op = 3'($urandom_range(OP_SW, OP_LB));
        addr   = pick_addr();
        if ((req_op == OP_LW || req_op == OP_SW) && $urandom_range(9, 0) != 0) begin
          addr[1:0] = 2'b00;
        end
        send_at(req_op, addr, $urandom);
      end else begin
        send_req(3'($urandom_range(7, 0)), $urandom, $urandom, $urandom);
      end
    end
    in_valid <= 1'b0;
    phase    <= PH_FREE;

    // Drain, then a few cycles for anything stray
    while (pending != 0) @(posedge clk);
    repeat (8) @(posedge clk);

    $display("Run covered %0d loads, %0d stores and %0d refused accesses,", load_count,
             store_count, fault_count);
    $display("under four throttle modes and a %0d-cycle output hold.", HoldCycles);
    if (pending != 0) begin
      $error("%0d results never arrived", pending);
    end
    if (fail_count == 0 && pending == 0) begin
      $display("** load_store_byte_memory: PASSED **");
    end else begin
      $display("** load_store_byte_memory: FAILED **");
    end
    $finish;
  end

  // Watchdog
  initial begin : watchdog
    #1000000;
    $display("** load_store_byte_memory: FAILED **");
    $finish;
  end

endmodule

// ===== sim.f =====
rtl/core/lsbm_pkg.sv
rtl/core/load_store_byte_memory.sv
dv/lsbm_access_checker.sv
dv/testbench.sv
